// ===== hw/rtl/gfr_pkg.sv =====
// Shared types and constants for the gain frame receiver.
// Depends on nothing; every other file of the block imports it.
package gfr_pkg;

	// Frame limit of the free-running position counter.
	localparam int unsigned FRAME_LIMIT_DEF = 64;

	// Framing bytes.
	localparam logic [7:0] SYNC0_BYTE = 8'hFF;
	localparam logic [7:0] SYNC1_BYTE = 8'h55;
	localparam logic [7:0] REPLY_LEN  = 8'd16;

	// Payload positions kept in the store: frame positions three to seven.
	localparam int unsigned STORE_BASE  = 3;
	localparam int unsigned STORE_DEPTH = 5;
	localparam int unsigned LEN_POS     = 2;

	// Command codes carried in payload byte five.
	localparam logic [7:0] CODE_SET_LO = 8'h01;
	localparam logic [7:0] CODE_SET_HI = 8'h04;
	localparam logic [7:0] CODE_REPLY  = 8'h05;

	// Reply frame: three header bytes and four words of four bytes.
	localparam int unsigned REPLY_COUNT = 19;
	localparam int unsigned REPLY_HDR   = 3;
	localparam int unsigned CNT_W       = $clog2(REPLY_COUNT);

	// Command queue between the parser and the result generator.
	localparam int unsigned QUEUE_DEPTH = 4;

	// Result kinds.
	localparam logic KIND_TX   = 1'b0;
	localparam logic KIND_GAIN = 1'b1;

	// One dispatched command.
	typedef struct packed {
		logic        is_reply;
		logic [1:0]  slot;
		logic [31:0] word;
	} cmd_t;

endpackage

// ===== hw/rtl/gfr_front.sv =====
// Byte parser of the gain frame receiver: tracks framing, keeps payload bytes
// and dispatches finished frames as commands. Depends on gfr_pkg.
module gfr_front
	import gfr_pkg::*;
#(
	parameter int unsigned FRAME_LIMIT = FRAME_LIMIT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	input  logic [7:0] rx_byte,
	output logic       cmd_push,
	output cmd_t       cmd
);

	localparam int unsigned POS_W = $clog2(FRAME_LIMIT);

	logic [7:0]       prev_q;
	logic             in_frame_q;
	logic [POS_W-1:0] pos_q;
	logic [7:0]       left_q;
	logic [7:0]       store_q [STORE_DEPTH];

	logic             is_mark;
	logic             start;
	logic [POS_W-1:0] pos_a;
	logic             in_frame_a;
	logic [POS_W:0]   pos_n;
	logic             limit_hit;
	logic [7:0]       left_d;
	logic [7:0]       store_d [STORE_DEPTH];
	logic             dispatch;
	logic [7:0]       code;

	always_comb begin
		is_mark    = (rx_byte == SYNC1_BYTE) && !in_frame_q;
		start      = is_mark && (prev_q == SYNC0_BYTE);
		pos_a      = start ? POS_W'(1) : pos_q;
		in_frame_a = in_frame_q || start;
		left_d     = left_q;
		for (int i = 0; i < STORE_DEPTH; i++) begin
			store_d[i] = store_q[i];
		end
		if (!is_mark && in_frame_q) begin
			if (pos_a > POS_W'(LEN_POS)) begin
				left_d = left_q - 8'd1;
			end else if (pos_a == POS_W'(LEN_POS)) begin
				left_d = rx_byte;
			end
			for (int i = 0; i < STORE_DEPTH; i++) begin
				if (pos_a == POS_W'(STORE_BASE + i)) begin
					store_d[i] = rx_byte;
				end
			end
		end
		pos_n     = {1'b0, pos_a} + (POS_W + 1)'(1);
		limit_hit = pos_n >= (POS_W + 1)'(FRAME_LIMIT);
		dispatch  = in_frame_a && !limit_hit && (left_d == 8'd0)
			&& (pos_n > (POS_W + 1)'(STORE_BASE));
		code      = store_d[STORE_DEPTH-1];

		cmd.is_reply = (code == CODE_REPLY);
		cmd.slot     = code[1:0] - 2'd1;
		cmd.word     = {store_d[3], store_d[2], store_d[1], store_d[0]};
		cmd_push     = byte_valid && dispatch
			&& (cmd.is_reply || ((code >= CODE_SET_LO) && (code <= CODE_SET_HI)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q     <= '0;
			in_frame_q <= 1'b0;
			pos_q      <= '0;
			left_q     <= '0;
			for (int i = 0; i < STORE_DEPTH; i++) begin
				store_q[i] <= '0;
			end
		end else if (byte_valid) begin
			if (!is_mark) begin
				prev_q <= rx_byte;
			end
			left_q <= left_d;
			for (int i = 0; i < STORE_DEPTH; i++) begin
				store_q[i] <= store_d[i];
			end
			if (limit_hit || dispatch) begin
				pos_q      <= '0;
				in_frame_q <= 1'b0;
			end else begin
				pos_q      <= pos_n[POS_W-1:0];
				in_frame_q <= in_frame_a;
			end
		end
	end

	// A frame always runs at position two or beyond once its mark is taken.
	a_frame_pos: assert property (@(posedge clk) disable iff (!arst_n)
		in_frame_q |-> (pos_q >= POS_W'(LEN_POS)))
		else $error("in frame at position below the length byte");

endmodule

// ===== hw/rtl/gfr_queue.sv =====
// Short command queue between parser and result generator.
// Depends on gfr_pkg for the command type and its depth.
module gfr_queue
	import gfr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t din,
	input  logic pop,
	output logic full,
	output logic empty,
	output cmd_t dout
);

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_QW = $clog2(QUEUE_DEPTH + 1);

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_q;
	logic [PTR_W-1:0]  rd_q;
	logic [CNT_QW-1:0] count_q;

	assign full  = (count_q == CNT_QW'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= wr_q + PTR_W'(1);
			end
			if (pop && !empty) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_QW'(push && !full) - CNT_QW'(pop && !empty);
		end
	end

	// The parser is held off while full, so no command is ever dropped.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("command pushed into a full queue");

endmodule

// ===== hw/rtl/gfr_back.sv =====
// Result generator: executes queued commands, holds the four gain words and
// drives the registered result stream. Depends on gfr_pkg.
module gfr_back
	import gfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_empty,
	input  cmd_t        cmd,
	output logic        cmd_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        out_kind,
	output logic        out_last,
	output logic [7:0]  out_byte,
	output logic [1:0]  out_slot,
	output logic [31:0] out_bits
);

	logic [31:0]      gain_q [4];
	logic             replying_q;
	logic [CNT_W-1:0] cnt_q;
	logic             valid_q;
	logic             kind_q;
	logic             last_q;
	logic [7:0]       byte_q;
	logic [1:0]       slot_q;
	logic [31:0]      bits_q;

	logic             load;
	logic [CNT_W-1:0] data_idx;
	logic [7:0]       reply_byte;

	assign load    = !valid_q || out_ready;
	assign cmd_pop = load && !replying_q && !cmd_empty;

	always_comb begin
		data_idx = cnt_q - CNT_W'(REPLY_HDR);
		if (cnt_q == CNT_W'(1)) begin
			reply_byte = SYNC1_BYTE;
		end else if (cnt_q == CNT_W'(2)) begin
			reply_byte = REPLY_LEN;
		end else begin
			reply_byte = gain_q[data_idx[3:2]][8*data_idx[1:0] +: 8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			replying_q <= 1'b0;
			cnt_q      <= '0;
			kind_q     <= KIND_TX;
			last_q     <= 1'b0;
			byte_q     <= '0;
			slot_q     <= '0;
			bits_q     <= '0;
			for (int i = 0; i < 4; i++) begin
				gain_q[i] <= '0;
			end
		end else if (load) begin
			if (replying_q) begin
				valid_q <= 1'b1;
				kind_q  <= KIND_TX;
				byte_q  <= reply_byte;
				slot_q  <= '0;
				bits_q  <= '0;
				last_q  <= (cnt_q == CNT_W'(REPLY_COUNT - 1));
				if (cnt_q == CNT_W'(REPLY_COUNT - 1)) begin
					replying_q <= 1'b0;
					cnt_q      <= '0;
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end else if (!cmd_empty) begin
				valid_q <= 1'b1;
				if (cmd.is_reply) begin
					kind_q     <= KIND_TX;
					byte_q     <= SYNC0_BYTE;
					slot_q     <= '0;
					bits_q     <= '0;
					last_q     <= 1'b0;
					replying_q <= 1'b1;
					cnt_q      <= CNT_W'(1);
				end else begin
					kind_q            <= KIND_GAIN;
					byte_q            <= '0;
					slot_q            <= cmd.slot;
					bits_q            <= cmd.word;
					last_q            <= 1'b1;
					gain_q[cmd.slot]  <= cmd.word;
				end
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = valid_q;
	assign out_kind  = kind_q;
	assign out_last  = last_q;
	assign out_byte  = byte_q;
	assign out_slot  = slot_q;
	assign out_bits  = bits_q;

	// A gain write is always a single, final result.
	a_gain_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && kind_q == KIND_GAIN) |-> last_q)
		else $error("gain write result not marked last");

	// A reply runs its counter only over the bytes after the first.
	a_reply_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		replying_q |-> (cnt_q != '0 && cnt_q < CNT_W'(REPLY_COUNT)))
		else $error("reply counter out of range");

endmodule

// ===== hw/rtl/gain_frame_receiver.sv =====
// Top level of the gain frame receiver: byte parser, command queue and
// result generator. Depends on gfr_pkg, gfr_front, gfr_queue and gfr_back.
//
//  Channel   Direction  Signals                    Content
//  s_*       in         tvalid tready tdata[7:0]   rx_byte
//  m_*       out        tvalid tready tdata tuser  tx_byte, gain_slot,
//                       tlast                      gain_bits; kind; last
//
// The parser takes one byte per cycle and settles framing in that cycle.
// A finished frame enters a four-entry command queue; the generator then
// gives one result per cycle: one for a gain write, nineteen for a reply.
// Input stalls only while the command queue is full; output stalls hold the
// registered result and let the queue absorb further commands.
// Reset clears framing state, the payload store, the gain words and queue.
module gain_frame_receiver
	import gfr_pkg::*;
#(
	parameter int unsigned FRAME_LIMIT = FRAME_LIMIT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [7:0] tx_byte, [9:8] gain_slot, [41:10] gain_bits
	output logic        m_tuser,   // [0] kind
	output logic        m_tlast
);

	logic        q_full;
	logic        q_empty;
	logic        q_push;
	logic        q_pop;
	cmd_t        q_din;
	cmd_t        q_dout;
	logic [7:0]  tx_byte;
	logic [1:0]  gain_slot;
	logic [31:0] gain_bits;

	// A byte is taken whenever the queue can hold a command it might create.
	assign s_tready = !q_full;

	gfr_front #(
		.FRAME_LIMIT(FRAME_LIMIT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(s_tvalid && s_tready),
		.rx_byte   (s_tdata),
		.cmd_push  (q_push),
		.cmd       (q_din)
	);

	gfr_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.din   (q_din),
		.pop   (q_pop),
		.full  (q_full),
		.empty (q_empty),
		.dout  (q_dout)
	);

	gfr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_empty(q_empty),
		.cmd      (q_dout),
		.cmd_pop  (q_pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_kind (m_tuser),
		.out_last (m_tlast),
		.out_byte (tx_byte),
		.out_slot (gain_slot),
		.out_bits (gain_bits)
	);

	// Result fields packed from the lowest bit up, padded to whole bytes.
	assign m_tdata = {6'd0, gain_bits, gain_slot, tx_byte};

endmodule
